### rtl/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step unit package
// Shared types, register indexes and constants of the fixed-point PID step
// unit: the input and result words, the configuration set and the word that
// the front end hands to the back end.
// ----------------------------------------------------------------------------
package pcs_pkg;

	// Item kinds carried in the input word.
	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_ENABLE  = 2'd1,
		KIND_DISABLE = 2'd2,
		KIND_RESET   = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_INPUT_MIN  = 3'd3,
		REG_INPUT_MAX  = 3'd4,
		REG_OUTPUT_MIN = 3'd5,
		REG_OUTPUT_MAX = 3'd6,
		REG_TOLERANCE  = 3'd7
	} reg_index_t;

	// What the back end does with a word from the front end.
	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CAND = 3'd1,
		ST_MUL  = 3'd2,
		ST_INT  = 3'd3,
		ST_OUT  = 3'd4
	} back_state_t;

	// Width of the exact P + I + D sum in Q.32.
	localparam int TOTAL_W = 81;
	// Width of the saturating error sum and of one multiplier slice.
	localparam int SUM_W   = 48;
	localparam int SLICE_W = 24;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [31:0]      ERR_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]      ERR_MIN = 32'sh8000_0000;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] measured;
		logic signed [31:0] setpoint;
	} item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               on_target;
	} result_t;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic signed [31:0] input_min;
		logic signed [31:0] input_max;
		logic signed [31:0] output_min;
		logic signed [31:0] output_max;
		logic        [15:0] tolerance;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_p:     32'sd0,
		gain_i:     32'sd0,
		gain_d:     32'sd0,
		input_min:  -32'sd65536,
		input_max:  32'sd65536,
		output_min: -32'sd65536,
		output_max: 32'sd65536,
		tolerance:  16'd3277
	};

	// Word passed from the front end to the back end.
	typedef struct packed {
		op_t                       op;
		logic signed [31:0]        err;
		logic signed [TOTAL_W-1:0] pd;
		logic                      on_target;
	} work_t;

endpackage

### rtl/pcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small flop queue
// First-in first-out queue in flip-flops with a valid/ready write side and a
// valid/ready read side. The oldest word is always shown on the read side.
// ----------------------------------------------------------------------------
module pcs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// Handshake status follows the fill count.
	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/pcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step front end
// Accepts input words, tracks the run state, classifies each word and forms
// the error, its difference to the previous error, the P and D terms and the
// on-target flag in a five-stage pipeline that stalls as a whole.
// ----------------------------------------------------------------------------
module pcs_front #(
	parameter bit CONTINUOUS_MODE = 1'b0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pcs_pkg::cfg_t   cfg,
	input  logic            push,
	output logic            full,
	input  pcs_pkg::item_t  item,
	output logic            word_valid,
	input  logic            word_ready,
	output pcs_pkg::work_t  word
);

	localparam int TW = pcs_pkg::TOTAL_W;

	logic               adv;
	logic               accept;
	logic               running_q;
	pcs_pkg::op_t       op_in;

	logic signed [31:0] in_min;
	logic signed [31:0] in_max;
	logic signed [31:0] gp;
	logic signed [31:0] gd;
	logic signed [31:0] meas;
	logic signed [31:0] setp;
	logic signed [31:0] sp_c;
	logic signed [32:0] e33;
	logic signed [32:0] span;
	logic        [32:0] mag;
	logic               wrap;
	logic signed [34:0] e_w;
	logic signed [34:0] e_sel;
	logic signed [31:0] e_sat;
	logic        [31:0] lmag;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	pcs_pkg::op_t       op_s1, op_s2, op_s3, op_s4, op_s5;
	logic signed [32:0] err_s1;
	logic signed [31:0] err_s2, err_s3, err_s4, err_s5;
	logic signed [31:0] prev_q;
	logic signed [31:0] last_q;
	logic signed [32:0] diff_s3;
	logic signed [31:0] last_s3;
	logic signed [63:0] pe_s4;
	logic signed [64:0] pdd_s4;
	logic signed [49:0] tspan_s4;
	logic        [31:0] lmag_s4;
	logic signed [TW-1:0] pd_s5;
	logic               ot_s5;

	assign in_min = cfg.input_min;
	assign in_max = cfg.input_max;
	assign gp     = cfg.gain_p;
	assign gd     = cfg.gain_d;
	assign meas   = item.measured;
	assign setp   = item.setpoint;

	// The whole pipeline moves unless the last stage holds a word the queue refuses.
	assign adv    = !(v_s5 && !word_ready);
	assign full   = !adv;
	assign accept = push && adv;

	// Classify the word against the run state at the time it arrives.
	always_comb begin
		case (item.kind)
			pcs_pkg::KIND_TICK:  op_in = running_q ? pcs_pkg::OP_TICK : pcs_pkg::OP_PASS;
			pcs_pkg::KIND_RESET: op_in = pcs_pkg::OP_CLEAR;
			default:             op_in = pcs_pkg::OP_PASS;
		endcase
	end

	// Stage 1 logic: clamp the setpoint to the input range when max exceeds min and form the exact error.
	always_comb begin
		sp_c = setp;
		if (in_max > in_min) begin
			if (setp > in_max) begin
				sp_c = in_max;
			end else if (setp < in_min) begin
				sp_c = in_min;
			end
		end
		e33 = 33'(sp_c) - 33'(meas);
	end

	// Stage 2 logic: wrap by the input span in continuous mode, then saturate.
	always_comb begin
		span  = 33'(in_max) - 33'(in_min);
		mag   = err_s1[32] ? (~err_s1 + 1'b1) : err_s1;
		wrap  = $signed({1'b0, mag, 1'b0}) > 35'(span);
		e_w   = (err_s1 > 0) ? (35'(err_s1) - 35'(span)) : (35'(err_s1) + 35'(span));
		e_sel = (CONTINUOUS_MODE && wrap) ? e_w : 35'(err_s1);
		if (e_sel[34:31] == 4'b0000 || e_sel[34:31] == 4'b1111) begin
			e_sat = e_sel[31:0];
		end else begin
			e_sat = e_sel[34] ? pcs_pkg::ERR_MIN : pcs_pkg::ERR_MAX;
		end
	end

	// Stage 4 logic: magnitude of the last error.
	assign lmag = last_s3[31] ? (~last_s3 + 1'b1) : last_s3;

	// Stage valid bits and the run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			running_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= push;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
			if (accept) begin
				case (item.kind)
					pcs_pkg::KIND_ENABLE:  running_q <= 1'b1;
					pcs_pkg::KIND_DISABLE: running_q <= 1'b0;
					pcs_pkg::KIND_RESET:   running_q <= 1'b0;
					default:               running_q <= running_q;
				endcase
			end
		end
	end

	// Previous and last error, updated in word order at stage 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			last_q <= '0;
		end else if (adv && v_s2) begin
			case (op_s2)
				pcs_pkg::OP_TICK: begin
					prev_q <= err_s2;
					last_q <= err_s2;
				end
				pcs_pkg::OP_CLEAR: begin
					prev_q <= '0;
				end
				default: begin
					prev_q <= prev_q;
				end
			endcase
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op_in;
			err_s1   <= e33;

			op_s2    <= op_s1;
			err_s2   <= e_sat;

			op_s3    <= op_s2;
			err_s3   <= err_s2;
			diff_s3  <= 33'(err_s2) - 33'(prev_q);
			last_s3  <= (op_s2 == pcs_pkg::OP_TICK) ? err_s2 : last_q;

			op_s4    <= op_s3;
			err_s4   <= err_s3;
			pe_s4    <= gp * err_s3;
			pdd_s4   <= gd * diff_s3;
			tspan_s4 <= $signed({1'b0, cfg.tolerance}) * span;
			lmag_s4  <= lmag;

			op_s5    <= op_s4;
			err_s5   <= err_s4;
			pd_s5    <= TW'(pe_s4) + TW'(pdd_s4);
			ot_s5    <= $signed({2'b00, lmag_s4, 16'h0000}) < tspan_s4;
		end
	end

	// Word to the back end.
	assign word_valid     = v_s5;
	assign word.op        = op_s5;
	assign word.err       = err_s5;
	assign word.pd        = pd_s5;
	assign word.on_target = ot_s5;

endmodule

### rtl/pcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step back end
// Carries out the words of the front end in order: runs the conditional
// integration of the error sum, adds the integral term to the P and D terms,
// clamps to the output range and keeps the held output.
// ----------------------------------------------------------------------------
module pcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pcs_pkg::cfg_t    cfg,
	input  logic             head_valid,
	output logic             head_pop,
	input  pcs_pkg::work_t   head,
	output logic             res_push,
	input  logic             res_ready,
	output pcs_pkg::result_t res_word
);

	localparam int TW   = pcs_pkg::TOTAL_W;
	localparam int SW   = pcs_pkg::SUM_W;
	localparam int LW   = pcs_pkg::SLICE_W;
	localparam int HW   = SW - LW;
	localparam int PH_W = 32 + HW;
	localparam int PL_W = 32 + LW + 1;

	pcs_pkg::back_state_t state_q, state_d;

	logic signed [SW-1:0]   sum_q;
	logic signed [31:0]     held_q;
	logic signed [31:0]     err_q;
	logic signed [TW-1:0]   pd_q;
	logic                   ot_q;
	logic signed [SW-1:0]   cand_q;
	logic signed [PH_W-1:0] pch_q, psh_q;
	logic signed [PL_W-1:0] pcl_q, psl_q;
	logic signed [TW-1:0]   isel_q;

	logic signed [31:0]     gi;
	logic signed [31:0]     out_min;
	logic signed [31:0]     out_max;
	logic signed [TW-1:0]   tmax;
	logic signed [TW-1:0]   tmin;
	logic signed [SW:0]     sum_ext;
	logic signed [SW-1:0]   cand;
	logic signed [HW-1:0]   chi, shi;
	logic signed [LW:0]     clo, slo;
	logic signed [TW-1:0]   iprod_c;
	logic signed [TW-1:0]   iprod_s;
	logic                   int_ok;
	logic signed [TW-1:0]   total;
	logic signed [31:0]     held_new;

	assign gi      = cfg.gain_i;
	assign out_min = cfg.output_min;
	assign out_max = cfg.output_max;

	// Output bounds scaled to the Q.32 product grid.
	assign tmax = $signed({{(TW-48){out_max[31]}}, out_max, 16'h0000});
	assign tmin = $signed({{(TW-48){out_min[31]}}, out_min, 16'h0000});

	// Candidate error sum, saturated to the sum width.
	always_comb begin
		sum_ext = (SW+1)'(sum_q) + (SW+1)'(err_q);
		if (sum_ext[SW] != sum_ext[SW-1]) begin
			cand = sum_ext[SW] ? pcs_pkg::SUM_MIN : pcs_pkg::SUM_MAX;
		end else begin
			cand = sum_ext[SW-1:0];
		end
	end

	// Multiplier slices: a signed upper part and an unsigned lower part.
	assign chi = $signed(cand_q[SW-1:LW]);
	assign clo = $signed({1'b0, cand_q[LW-1:0]});
	assign shi = $signed(sum_q[SW-1:LW]);
	assign slo = $signed({1'b0, sum_q[LW-1:0]});

	// Recombine the partial products and test the integration bound.
	assign iprod_c = (TW'(pch_q) <<< LW) + TW'(pcl_q);
	assign iprod_s = (TW'(psh_q) <<< LW) + TW'(psl_q);
	assign int_ok  = (iprod_c < tmax) && (iprod_c > tmin);

	// Total output and its clamp.
	always_comb begin
		total = isel_q + pd_q;
		if (total > tmax) begin
			held_new = out_max;
		end else if (total < tmin) begin
			held_new = out_min;
		end else begin
			held_new = total[47:16];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d            = state_q;
		head_pop           = 1'b0;
		res_push           = 1'b0;
		res_word.drive     = held_q;
		res_word.on_target = head.on_target;
		case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (head_valid) begin
					if (head.op == pcs_pkg::OP_TICK) begin
						head_pop = 1'b1;
						state_d  = pcs_pkg::ST_CAND;
					end else if (res_ready) begin
						head_pop = 1'b1;
						res_push = 1'b1;
						if (head.op == pcs_pkg::OP_CLEAR) begin
							res_word.drive = '0;
						end
					end
				end
			end
			pcs_pkg::ST_CAND: begin
				state_d = pcs_pkg::ST_MUL;
			end
			pcs_pkg::ST_MUL: begin
				state_d = pcs_pkg::ST_INT;
			end
			pcs_pkg::ST_INT: begin
				state_d = pcs_pkg::ST_OUT;
			end
			pcs_pkg::ST_OUT: begin
				res_word.drive     = held_new;
				res_word.on_target = ot_q;
				if (res_ready) begin
					res_push = 1'b1;
					state_d  = pcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcs_pkg::ST_IDLE;
			end
		endcase
	end

	// Controller state: error sum and held output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			held_q <= '0;
		end else begin
			if (state_q == pcs_pkg::ST_IDLE && head_pop && head.op == pcs_pkg::OP_CLEAR) begin
				sum_q  <= '0;
				held_q <= '0;
			end
			if (state_q == pcs_pkg::ST_INT && int_ok) begin
				sum_q <= cand_q;
			end
			if (state_q == pcs_pkg::ST_OUT && res_ready) begin
				held_q <= held_new;
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (state_q == pcs_pkg::ST_IDLE && head_pop) begin
			err_q <= head.err;
			pd_q  <= head.pd;
			ot_q  <= head.on_target;
		end
		if (state_q == pcs_pkg::ST_CAND) begin
			cand_q <= cand;
		end
		if (state_q == pcs_pkg::ST_MUL) begin
			pch_q <= gi * chi;
			pcl_q <= gi * clo;
			psh_q <= gi * shi;
			psl_q <= gi * slo;
		end
		if (state_q == pcs_pkg::ST_INT) begin
			isel_q <= int_ok ? iprod_c : iprod_s;
		end
	end

endmodule

### rtl/pid_controller_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step unit
// Fixed-point Q16.16 PID step with setpoint clamp, optional continuous error
// wrap, conditional integration and output clamp, behind queue interfaces.
// ----------------------------------------------------------------------------
// The unit takes one input word per cycle while full is low and gives one
// result word for every input word, in order, on the result side while empty
// is low. Input words pass a five-stage front pipeline, then a four-entry
// queue, then the back end. In the back end, enable, disable and reset words
// and ticks that arrive while stopped are handled in the idle state alone; a
// running tick steps through the idle, candidate, multiply, integrate and output
// states of the error-sum loop: saturating add, integral-gain multiply, bound
// compare, then output sum and clamp must finish before the next tick can form
// its sum. Configuration writes are always ready and must only be made while
// no word is in flight.
module pid_controller_step_unit #(
	parameter bit CONTINUOUS_MODE = 1'b0,
	parameter int MID_DEPTH       = 4,
	parameter int RES_DEPTH       = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  pcs_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output pcs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	localparam int WORK_W = $bits(pcs_pkg::work_t);
	localparam int RES_W  = $bits(pcs_pkg::result_t);

	pcs_pkg::cfg_t    cfg_q;
	logic             front_valid;
	logic             mid_ready;
	pcs_pkg::work_t   front_word;
	logic [WORK_W-1:0] mid_rd;
	logic             head_valid;
	logic             head_pop;
	pcs_pkg::work_t   head;
	logic             res_push;
	logic             res_ready;
	pcs_pkg::result_t res_word;
	logic [RES_W-1:0] res_rd;
	logic             res_valid;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pcs_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (pcs_pkg::reg_index_t'(cfg_index))
				pcs_pkg::REG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				pcs_pkg::REG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				pcs_pkg::REG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				pcs_pkg::REG_INPUT_MIN:  cfg_q.input_min  <= cfg_data;
				pcs_pkg::REG_INPUT_MAX:  cfg_q.input_max  <= cfg_data;
				pcs_pkg::REG_OUTPUT_MIN: cfg_q.output_min <= cfg_data;
				pcs_pkg::REG_OUTPUT_MAX: cfg_q.output_max <= cfg_data;
				pcs_pkg::REG_TOLERANCE:  cfg_q.tolerance  <= cfg_data[15:0];
				default:                 cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front end: run state, error and P/D terms.
	pcs_front #(
		.CONTINUOUS_MODE(CONTINUOUS_MODE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.item       (item),
		.word_valid (front_valid),
		.word_ready (mid_ready),
		.word       (front_word)
	);

	// Queue between the front and back ends.
	pcs_queue #(
		.WIDTH(WORK_W),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (mid_ready),
		.wr_data  (front_word),
		.rd_valid (head_valid),
		.rd_ready (head_pop),
		.rd_data  (mid_rd)
	);

	assign head = pcs_pkg::work_t'(mid_rd);

	// Back end: integration and output.
	pcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head),
		.res_push   (res_push),
		.res_ready  (res_ready),
		.res_word   (res_word)
	);

	// Result queue toward the consumer.
	pcs_queue #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_push),
		.wr_ready (res_ready),
		.wr_data  (res_word),
		.rd_valid (res_valid),
		.rd_ready (pop),
		.rd_data  (res_rd)
	);

	assign empty  = !res_valid;
	assign result = pcs_pkg::result_t'(res_rd);

endmodule

### sim/tb_pid_controller_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step unit testbench
// Drives input words into the step unit and checks every result word against
// a cycle-free model of the fixed-point PID step. A short directed sequence
// covers the reset state, the field extremes, inverted ranges and every item
// kind. A run of ticks at the largest error with integration held open lets
// the error sum grow on every tick. Randomized phases with fresh register
// settings follow. Both queue sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_controller_step_unit;

	localparam bit CONT_MODE   = 1'b0;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 152;
	// Ticks at the largest error while integration stays open.
	localparam int SAT_TICKS   = 24;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t           what;
		pcs_pkg::item_t      word;
		bit                  typed;
		pcs_pkg::result_t    want;
		pcs_pkg::reg_index_t index;
		logic [31:0]         data;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             push;
	logic             full;
	pcs_pkg::item_t   item;
	logic             empty;
	logic             pop;
	pcs_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [2:0]       cfg_index;
	logic [31:0]      cfg_data;

	// Model state and register copy.
	pcs_pkg::cfg_t                    cfg_m      = pcs_pkg::CFG_RESET;
	bit                               run_m      = 1'b0;
	logic signed [31:0]               last_err_m = '0;
	logic signed [31:0]               prev_err_m = '0;
	logic signed [pcs_pkg::SUM_W-1:0] sum_m      = '0;
	logic signed [31:0]               held_m     = '0;

	pcs_pkg::result_t outputs_due[$];
	row_t    plan[$];
	int      fail_count  = 0;
	int      cycle_count = 0;
	bit      steady_in   = 1'b0;
	bit      steady_out  = 1'b0;

	pid_controller_step_unit #(
		.CONTINUOUS_MODE(CONT_MODE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One running tick: clamp, error, conditional integration, clamped output.
	function automatic void pid_tick(logic signed [31:0] meas, logic signed [31:0] sp_in);
		longint span, sp, e, mag, cand;
		logic signed [95:0] tmax, tmin, prod, total, gp, gi, gd, ev, pv, sv, cv;
		span = longint'($signed(cfg_m.input_max)) - longint'($signed(cfg_m.input_min));
		sp = sp_in;
		if ($signed(cfg_m.input_max) > $signed(cfg_m.input_min)) begin
			if (sp > cfg_m.input_max) sp = cfg_m.input_max;
			else if (sp < cfg_m.input_min) sp = cfg_m.input_min;
		end
		e = sp - meas;
		if (CONT_MODE) begin
			mag = (e < 0) ? -e : e;
			if (mag * 2 > span) e = (e > 0) ? e - span : e + span;
		end
		if (e > pcs_pkg::ERR_MAX) e = pcs_pkg::ERR_MAX;
		else if (e < pcs_pkg::ERR_MIN) e = pcs_pkg::ERR_MIN;
		last_err_m = e[31:0];

		// The sum only moves while the integral term stays strictly in range.
		cand = longint'(sum_m) + e;
		if (cand > pcs_pkg::SUM_MAX) cand = pcs_pkg::SUM_MAX;
		else if (cand < pcs_pkg::SUM_MIN) cand = pcs_pkg::SUM_MIN;
		tmax = $signed(cfg_m.output_max);
		tmax = tmax <<< 16;
		tmin = $signed(cfg_m.output_min);
		tmin = tmin <<< 16;
		gp = $signed(cfg_m.gain_p);
		gi = $signed(cfg_m.gain_i);
		gd = $signed(cfg_m.gain_d);
		cv = cand;
		prod = gi * cv;
		if (prod < tmax && prod > tmin) sum_m = cand[pcs_pkg::SUM_W-1:0];

		ev = e;
		pv = prev_err_m;
		sv = sum_m;
		total = gp * ev + gi * sv + gd * (ev - pv);
		prev_err_m = e[31:0];
		if (total > tmax) held_m = cfg_m.output_max;
		else if (total < tmin) held_m = cfg_m.output_min;
		else held_m = total[47:16];
	endfunction

	// Applies one input word to the model and returns the result it yields.
	function automatic pcs_pkg::result_t pid_step(pcs_pkg::item_t w);
		pcs_pkg::result_t r;
		longint mag, span, tol;
		case (w.kind)
			pcs_pkg::KIND_TICK: begin
				if (run_m) pid_tick(w.measured, w.setpoint);
			end
			pcs_pkg::KIND_ENABLE: run_m = 1'b1;
			pcs_pkg::KIND_DISABLE: run_m = 1'b0;
			default: begin
				run_m = 1'b0;
				prev_err_m = '0;
				sum_m = '0;
				held_m = '0;
			end
		endcase
		mag = last_err_m;
		if (mag < 0) mag = -mag;
		span = longint'($signed(cfg_m.input_max)) - longint'($signed(cfg_m.input_min));
		tol = cfg_m.tolerance;
		r.drive = held_m;
		r.on_target = (mag * 65536 < tol * span);
		return r;
	endfunction

	function automatic void row_item(pcs_pkg::kind_t k, logic [31:0] m, logic [31:0] s,
		bit typed = 1'b0, logic [31:0] drv = '0, bit on = 1'b0);
		row_t r;
		r.what = ROW_ITEM;
		r.word.kind = k;
		r.word.measured = m;
		r.word.setpoint = s;
		r.typed = typed;
		r.want.drive = drv;
		r.want.on_target = on;
		r.index = pcs_pkg::REG_GAIN_P;
		r.data = '0;
		plan.push_back(r);
	endfunction

	function automatic void row_cfg(pcs_pkg::reg_index_t idx, logic [31:0] d);
		row_t r;
		r.what = ROW_CFG;
		r.word = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.index = idx;
		r.data = d;
		plan.push_back(r);
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] base;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 4))
					0: return pcs_pkg::ERR_MIN;
					1: return pcs_pkg::ERR_MAX;
					2: return '0;
					3: return cfg_m.input_min;
					default: return cfg_m.input_max;
				endcase
			end
			default: begin
				case ($urandom_range(0, 2))
					0: base = cfg_m.input_min;
					1: base = cfg_m.input_max;
					default: base = '0;
				endcase
				return base + (int'($urandom) >>> (31 - $urandom_range(0, 22)));
			end
		endcase
	endfunction

	function automatic pcs_pkg::item_t rand_word();
		pcs_pkg::item_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 92) w.kind = pcs_pkg::KIND_TICK;
		else if (pick < 95) w.kind = pcs_pkg::KIND_ENABLE;
		else if (pick < 98) w.kind = pcs_pkg::KIND_DISABLE;
		else w.kind = pcs_pkg::KIND_RESET;
		// Get back to running soon after a stop so most ticks do real work.
		if (!run_m && $urandom_range(0, 3) == 0) w.kind = pcs_pkg::KIND_ENABLE;
		w.measured = rand_value();
		w.setpoint = rand_value();
		return w;
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return pcs_pkg::ERR_MAX;
			2: return pcs_pkg::ERR_MIN;
			3: return $urandom;
			default: return int'($urandom) >>> $urandom_range(10, 20);
		endcase
	endfunction

	// Full, inverted, degenerate or ordinary ranges.
	function automatic void rand_range(output int lo, output int hi);
		case ($urandom_range(0, 9))
			0: begin
				lo = pcs_pkg::ERR_MIN;
				hi = pcs_pkg::ERR_MAX;
			end
			1: begin
				lo = int'($urandom_range(1, 32'h0004_0000));
				hi = -lo;
			end
			2: begin
				lo = int'($urandom) >>> 8;
				hi = lo;
			end
			default: begin
				lo = -int'($urandom_range(1, 32'h0010_0000));
				hi = int'($urandom_range(1, 32'h0010_0000));
			end
		endcase
	endfunction

	task automatic write_reg(pcs_pkg::reg_index_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pcs_pkg::REG_GAIN_P:     cfg_m.gain_p = d;
			pcs_pkg::REG_GAIN_I:     cfg_m.gain_i = d;
			pcs_pkg::REG_GAIN_D:     cfg_m.gain_d = d;
			pcs_pkg::REG_INPUT_MIN:  cfg_m.input_min = d;
			pcs_pkg::REG_INPUT_MAX:  cfg_m.input_max = d;
			pcs_pkg::REG_OUTPUT_MIN: cfg_m.output_min = d;
			pcs_pkg::REG_OUTPUT_MAX: cfg_m.output_max = d;
			default:                 cfg_m.tolerance = d[15:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_random_cfg();
		int lo, hi, pick;
		write_reg(pcs_pkg::REG_GAIN_P, rand_gain());
		write_reg(pcs_pkg::REG_GAIN_I, rand_gain());
		write_reg(pcs_pkg::REG_GAIN_D, rand_gain());
		rand_range(lo, hi);
		write_reg(pcs_pkg::REG_INPUT_MIN, lo);
		write_reg(pcs_pkg::REG_INPUT_MAX, hi);
		rand_range(lo, hi);
		write_reg(pcs_pkg::REG_OUTPUT_MIN, lo);
		write_reg(pcs_pkg::REG_OUTPUT_MAX, hi);
		pick = $urandom_range(0, 5);
		if (pick == 0) write_reg(pcs_pkg::REG_TOLERANCE, 32'h0);
		else if (pick == 1) write_reg(pcs_pkg::REG_TOLERANCE, 32'hFFFF);
		else write_reg(pcs_pkg::REG_TOLERANCE, $urandom_range(0, 65535));
	endtask

	// Sends one word after a random gap and records what it should return.
	task automatic send_word(pcs_pkg::item_t w, bit typed = 1'b0,
		pcs_pkg::result_t want = '0);
		int gap;
		pcs_pkg::result_t due;
		gap = steady_in ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
		repeat (gap) begin
			@(negedge clk);
			push = 1'b0;
		end
		@(negedge clk);
		push = 1'b1;
		item = w;
		do @(posedge clk); while (full);
		due = pid_step(w);
		if (typed) due = want;
		outputs_due.push_back(due);
	endtask

	// Holds the input side until every expected result word has come back.
	task automatic wait_idle();
		@(negedge clk);
		push = 1'b0;
		while (outputs_due.size() != 0) @(posedge clk);
	endtask

	// Result side: random stalls, then compare each word with the oldest expectation.
	initial begin
		int stall;
		pcs_pkg::result_t want;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady_out ? 0 : $urandom_range(0, 5);
			if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
			repeat (stall) begin
				@(negedge clk);
				pop = 1'b0;
			end
			@(negedge clk);
			pop = 1'b1;
			do @(posedge clk); while (empty);
			if (outputs_due.size() == 0) begin
				$error("result word with nothing expected: drive %0d", result.drive);
				fail_count++;
			end else begin
				want = outputs_due.pop_front();
				if (result.drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, result.drive);
					fail_count++;
				end
				if (result.on_target !== want.on_target) begin
					$error("on_target: expected %0d, got %0d", want.on_target,
						result.on_target);
					fail_count++;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		pcs_pkg::item_t w;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = pcs_pkg::REG_GAIN_P;
		cfg_data = '0;

		// Reset state: all gains zero, so the drive stays at zero.
		row_item(pcs_pkg::KIND_TICK, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1);
		row_item(pcs_pkg::KIND_ENABLE, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1);
		row_item(pcs_pkg::KIND_TICK, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1);
		row_item(pcs_pkg::KIND_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
		row_item(pcs_pkg::KIND_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
		row_item(pcs_pkg::KIND_DISABLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
		row_item(pcs_pkg::KIND_TICK, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0);
		row_item(pcs_pkg::KIND_RESET, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0);
		// Ordinary gains with the setpoint clamp in play.
		row_cfg(pcs_pkg::REG_GAIN_P, 32'h0001_0000);
		row_cfg(pcs_pkg::REG_GAIN_I, 32'h0000_0100);
		row_cfg(pcs_pkg::REG_GAIN_D, 32'h0000_8000);
		row_item(pcs_pkg::KIND_ENABLE, 32'h0, 32'h0);
		row_item(pcs_pkg::KIND_TICK, 32'h0000_4000, 32'h0000_8000);
		row_item(pcs_pkg::KIND_TICK, 32'hFFFF_8000, 32'h0002_0000);
		row_item(pcs_pkg::KIND_TICK, 32'h0000_1000, 32'h0000_1000);
		row_item(pcs_pkg::KIND_DISABLE, 32'h0, 32'h0);
		row_item(pcs_pkg::KIND_RESET, 32'h0, 32'h0);
		// Extreme register settings.
		row_cfg(pcs_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
		row_cfg(pcs_pkg::REG_GAIN_I, 32'h8000_0000);
		row_cfg(pcs_pkg::REG_GAIN_D, 32'h8000_0000);
		row_cfg(pcs_pkg::REG_INPUT_MIN, 32'h8000_0000);
		row_cfg(pcs_pkg::REG_INPUT_MAX, 32'h7FFF_FFFF);
		row_cfg(pcs_pkg::REG_OUTPUT_MIN, 32'h8000_0000);
		row_cfg(pcs_pkg::REG_OUTPUT_MAX, 32'h7FFF_FFFF);
		row_cfg(pcs_pkg::REG_TOLERANCE, 32'hFFFF);
		row_item(pcs_pkg::KIND_ENABLE, 32'h0, 32'h0);
		row_item(pcs_pkg::KIND_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
		row_item(pcs_pkg::KIND_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
		row_item(pcs_pkg::KIND_TICK, 32'h0, 32'h0);
		// Inverted input and output ranges, zero tolerance.
		row_cfg(pcs_pkg::REG_INPUT_MIN, 32'h0001_0000);
		row_cfg(pcs_pkg::REG_INPUT_MAX, 32'hFFFF_0000);
		row_cfg(pcs_pkg::REG_OUTPUT_MIN, 32'h0001_0000);
		row_cfg(pcs_pkg::REG_OUTPUT_MAX, 32'hFFFF_0000);
		row_cfg(pcs_pkg::REG_TOLERANCE, 32'h0);
		row_item(pcs_pkg::KIND_TICK, 32'h0000_0123, 32'h7FFF_FFFF);
		row_item(pcs_pkg::KIND_TICK, 32'hFFFF_FFFB, 32'h0000_0005);
		row_item(pcs_pkg::KIND_RESET, 32'h0, 32'h0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].what == ROW_CFG) begin
				wait_idle();
				write_reg(plan[i].index, plan[i].data);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		// Integral gain zero keeps integration open; the sum grows, then shrinks.
		wait_idle();
		write_reg(pcs_pkg::REG_GAIN_P, 32'h0);
		write_reg(pcs_pkg::REG_GAIN_I, 32'h0);
		write_reg(pcs_pkg::REG_GAIN_D, 32'h0);
		write_reg(pcs_pkg::REG_INPUT_MIN, pcs_pkg::CFG_RESET.input_min);
		write_reg(pcs_pkg::REG_INPUT_MAX, pcs_pkg::CFG_RESET.input_max);
		write_reg(pcs_pkg::REG_OUTPUT_MIN, pcs_pkg::CFG_RESET.output_min);
		write_reg(pcs_pkg::REG_OUTPUT_MAX, pcs_pkg::CFG_RESET.output_max);
		write_reg(pcs_pkg::REG_TOLERANCE, pcs_pkg::CFG_RESET.tolerance);
		steady_in = 1'b1;
		steady_out = 1'b1;
		w = '0;
		w.kind = pcs_pkg::KIND_ENABLE;
		send_word(w);
		w.kind = pcs_pkg::KIND_TICK;
		w.measured = pcs_pkg::ERR_MIN;
		w.setpoint = pcs_pkg::ERR_MAX;
		repeat (SAT_TICKS) send_word(w);
		w.measured = pcs_pkg::ERR_MAX;
		w.setpoint = pcs_pkg::ERR_MIN;
		repeat (4) send_word(w);
		steady_in = 1'b0;

		// Random phases, each with fresh register settings on an idle block.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			load_random_cfg();
			for (int n = 0; n < PHASE_WORDS; n++) begin
				send_word(rand_word());
				if ($urandom_range(0, 199) == 0) wait_idle();
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
rtl/pcs_pkg.sv
rtl/pcs_queue.sv
rtl/pcs_front.sv
rtl/pcs_back.sv
rtl/pid_controller_step_unit.sv
sim/tb_pid_controller_step_unit.sv
